/* design/scma_pkg.sv */
// Shared types and constants for the sparse clipped moment accumulator.
package scma_pkg;

  localparam int MAX_COLUMNS = 32768;

  localparam int CMD_W    = 2;
  localparam int COLUMN_W = 16;
  localparam int VALUE_W  = 24;
  localparam int SUM_W    = 40;
  localparam int SQ_W     = 63;
  localparam int PROD_W   = 2 * VALUE_W;

  localparam logic [COLUMN_W-1:0] ACTIVE_RESET = 16'h8000;

  localparam logic [CMD_W-1:0] CMD_SET_CLIP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] clip;
    logic signed [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]           sum_sq;
  } entry_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sum_sq;
  } sums_t;

endpackage

/* design/sparse_clipped_moment_accumulator.sv */
// Top level: column memory read-modify-write sequencer with registered result.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | cmd_i, column_i, value_i
//  out     | out | out_valid_o/out_stall_i| result_column_o, clipped_sum_o, clipped_sum_sq_o
//  cfg     | in  | cfg_we_i             | cfg_wdata_i (active_columns)
//
// set_clip, dropped items and cmd 3 leave the sequencer idle; read passes through a read
// state, held there while the result register is still held; accumulate passes through
// memory read, clip, square, saturating add and write-back, one registered stage each.
// Reset clears control state only; column memory contents are undefined until set_clip.
// A result waits in the output register while the next item is taken.
module sparse_clipped_moment_accumulator #(
  parameter int MaxColumns = scma_pkg::MAX_COLUMNS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scma_pkg::COLUMN_W-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [scma_pkg::CMD_W-1:0]           cmd_i,
  input  logic [scma_pkg::COLUMN_W-1:0]        column_i,
  input  logic signed [scma_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [scma_pkg::COLUMN_W-1:0]        result_column_o,
  output logic signed [scma_pkg::SUM_W-1:0]    clipped_sum_o,
  output logic [scma_pkg::SQ_W-1:0]            clipped_sum_sq_o
);

  localparam int AddrW = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLIP,
    ST_SQ,
    ST_ADD
  } state_e;

  state_e state_q;
  logic [scma_pkg::COLUMN_W-1:0] active_q;
  logic [scma_pkg::COLUMN_W-1:0] col_q;
  logic signed [scma_pkg::VALUE_W-1:0] val_q;
  logic signed [scma_pkg::VALUE_W-1:0] c_q;
  logic [scma_pkg::PROD_W-1:0] sq_q;
  logic out_valid_q;
  logic [scma_pkg::COLUMN_W-1:0] res_col_q;
  scma_pkg::sums_t res_q;

  logic in_xfer, out_xfer, in_range;
  logic we;
  logic [AddrW-1:0] waddr;
  scma_pkg::entry_t wdata, rdata;
  scma_pkg::sums_t old_sums, new_sums;
  logic signed [scma_pkg::PROD_W-1:0] prod;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign in_range   = (column_i < active_q) && (32'(column_i) < MaxColumns);

  always_comb begin
    we    = 1'b0;
    waddr = col_q[AddrW-1:0];
    wdata = '{clip: rdata.clip, sum: new_sums.sum, sum_sq: new_sums.sum_sq};
    if (in_xfer && in_range && cmd_i == scma_pkg::CMD_SET_CLIP) begin
      we    = 1'b1;
      waddr = column_i[AddrW-1:0];
      wdata = '{clip: value_i, sum: '0, sum_sq: '0};
    end else if (state_q == ST_ADD) begin
      we = 1'b1;
    end
  end

  scma_ram #(
    .Depth (MaxColumns),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (in_xfer),
    .raddr_i (column_i[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign old_sums = '{sum: rdata.sum, sum_sq: rdata.sum_sq};

  scma_sat u_sat (
    .old_i     (old_sums),
    .clipped_i (c_q),
    .square_i  (sq_q),
    .new_o     (new_sums)
  );

  assign prod = c_q * c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= scma_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_READ && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && in_range) begin
            case (cmd_i)
              scma_pkg::CMD_ACCUMULATE: state_q <= ST_CLIP;
              scma_pkg::CMD_READ:       state_q <= ST_READ;
              default:                  state_q <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        ST_CLIP: state_q <= ST_SQ;
        ST_SQ:   state_q <= ST_ADD;
        ST_ADD:  state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      col_q <= column_i;
      val_q <= value_i;
    end
    if (state_q == ST_CLIP) begin
      c_q <= (val_q < rdata.clip) ? val_q : rdata.clip;
    end
    if (state_q == ST_SQ) begin
      sq_q <= prod;
    end
    if (state_q == ST_READ && (!out_valid_q || !out_stall_i)) begin
      res_col_q <= col_q;
      res_q     <= old_sums;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_column_o  = res_col_q;
  assign clipped_sum_o    = res_q.sum;
  assign clipped_sum_sq_o = res_q.sum_sq;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_READ))
    else $error("result appeared without a read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQ |-> c_q <= rdata.clip)
    else $error("clipped value exceeds stored clip");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLIP |=> state_q == ST_SQ ##1 state_q == ST_ADD ##1 state_q == ST_IDLE)
    else $error("accumulate sequence broken");

endmodule

/* design/scma_ram.sv */
// Single-port-write, registered-read column memory.
module scma_ram #(
  parameter int Depth = scma_pkg::MAX_COLUMNS,
  parameter int AddrW = 15
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  scma_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output scma_pkg::entry_t     rdata_o
);

  scma_pkg::entry_t mem_q [Depth];
  scma_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/scma_sat.sv */
// Saturating update of a column's sum and sum of squares.
module scma_sat (
  input  scma_pkg::sums_t                        old_i,
  input  logic signed [scma_pkg::VALUE_W-1:0]    clipped_i,
  input  logic [scma_pkg::PROD_W-1:0]            square_i,
  output scma_pkg::sums_t                        new_o
);

  logic signed [scma_pkg::SUM_W:0] sum_ext;
  logic [scma_pkg::SQ_W:0]         sq_ext;

  assign sum_ext = {old_i.sum[scma_pkg::SUM_W-1], old_i.sum}
                 + {{(scma_pkg::SUM_W + 1 - scma_pkg::VALUE_W){clipped_i[scma_pkg::VALUE_W-1]}},
                    clipped_i};
  assign sq_ext  = {1'b0, old_i.sum_sq}
                 + {{(scma_pkg::SQ_W + 1 - scma_pkg::PROD_W){1'b0}}, square_i};

  always_comb begin
    if (sum_ext[scma_pkg::SUM_W] != sum_ext[scma_pkg::SUM_W-1]) begin
      new_o.sum = sum_ext[scma_pkg::SUM_W]
                ? {1'b1, {(scma_pkg::SUM_W-1){1'b0}}}
                : {1'b0, {(scma_pkg::SUM_W-1){1'b1}}};
    end else begin
      new_o.sum = sum_ext[scma_pkg::SUM_W-1:0];
    end
    if (sq_ext[scma_pkg::SQ_W]) begin
      new_o.sum_sq = {scma_pkg::SQ_W{1'b1}};
    end else begin
      new_o.sum_sq = sq_ext[scma_pkg::SQ_W-1:0];
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the sparse clipped moment accumulator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scma_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;
  localparam logic [63:0] SQ_HI = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [COLUMN_W-1:0]     col;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
  } col_sums_t;

  typedef struct packed {
    logic [CMD_W-1:0]          op;
    logic [COLUMN_W-1:0]       col;
    logic [VALUE_W-1:0]        val;
    logic                      typed;
    logic signed [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]           sq;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_SET_CLIP,   16'd0,     24'h000100, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd0,     24'h000000, 1'b1, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd0,     24'h000080, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd0,     24'h7FFFFF, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd0,     24'hFFFFFF, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd0,     24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_SET_CLIP,   16'd32767, 24'h800000, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd32767, 24'h7FFFFF, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd32767, 24'hFFFFFF, 1'b1, -40'sd8388608, 63'h4000_0000_0000},
    '{CMD_SET_CLIP,   16'd32767, 24'h7FFFFF, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd32767, 24'h800000, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd32767, 24'h7FFFFF, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd32767, 24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd32768, 24'h000005, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd32768, 24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd65535, 24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_UNUSED,     16'd0,     24'h123456, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd0,     24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_SET_CLIP,   16'd0,     24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd0,     24'h000000, 1'b1, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd0,     24'h555555, 1'b0, 40'sd0, 63'd0},
    '{CMD_ACCUMULATE, 16'd0,     24'hAAAAAA, 1'b0, 40'sd0, 63'd0},
    '{CMD_READ,       16'd0,     24'h000000, 1'b0, 40'sd0, 63'd0},
    '{CMD_SET_CLIP,   16'hAAAA,  24'h555555, 1'b0, 40'sd0, 63'd0},
    '{CMD_UNUSED,     16'd65535, 24'hFFFFFF, 1'b0, 40'sd0, 63'd0}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [COLUMN_W-1:0]        cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [CMD_W-1:0]           cmd_i;
  logic [COLUMN_W-1:0]        column_i;
  logic signed [VALUE_W-1:0]  value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [COLUMN_W-1:0]        result_column_o;
  logic signed [SUM_W-1:0]    clipped_sum_o;
  logic [SQ_W-1:0]            clipped_sum_sq_o;

  // predictor state
  logic signed [VALUE_W-1:0] clip_mem [MAX_COLUMNS];
  logic signed [SUM_W-1:0]   sum_mem  [MAX_COLUMNS];
  logic [SQ_W-1:0]           sq_mem   [MAX_COLUMNS];
  bit                        col_set  [MAX_COLUMNS];
  logic [COLUMN_W-1:0]       active_cols = ACTIVE_RESET;

  col_sums_t sums_due [$];
  int        mismatches = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;

  sparse_clipped_moment_accumulator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .column_i         (column_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_column_o  (result_column_o),
    .clipped_sum_o    (clipped_sum_o),
    .clipped_sum_sq_o (clipped_sum_sq_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic note_fail(input string msg);
    if (mismatches < 10) $display("%t  %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic fold_item(input logic [CMD_W-1:0] op, input logic [COLUMN_W-1:0] col,
                           input logic signed [VALUE_W-1:0] val,
                           output bit has_res, output col_sums_t res);
    logic signed [VALUE_W-1:0] c;
    longint acc;
    longint cl;
    longint mag;
    logic [63:0] sq;
    has_res = 1'b0;
    res = '0;
    if (col >= active_cols || col >= MAX_COLUMNS) return;
    case (op)
      CMD_SET_CLIP: begin
        clip_mem[col] = val;
        sum_mem[col]  = '0;
        sq_mem[col]   = '0;
        col_set[col]  = 1'b1;
      end
      CMD_ACCUMULATE: begin
        c   = (val < clip_mem[col]) ? val : clip_mem[col];
        cl  = c;
        acc = sum_mem[col];
        acc = acc + cl;
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        mag = (cl < 0) ? -cl : cl;
        sq  = {1'b0, sq_mem[col]} + 64'(mag * mag);
        if (sq > SQ_HI) sq = SQ_HI;
        sum_mem[col] = acc[SUM_W-1:0];
        sq_mem[col]  = sq[SQ_W-1:0];
      end
      CMD_READ: begin
        has_res = 1'b1;
        res = col_sums_t'{col, sum_mem[col], sq_mem[col]};
      end
      default: ;
    endcase
  endtask

  // one transfer on the input channel; a typed row overrides the predicted sums
  task automatic offer(input logic [CMD_W-1:0] op, input logic [COLUMN_W-1:0] col,
                       input logic [VALUE_W-1:0] val, input logic typed,
                       input col_sums_t typed_res);
    bit has_res;
    col_sums_t res;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 37) begin
      in_valid_i = 1'b0;
      cmd_i      = CMD_W'($urandom);
      column_i   = COLUMN_W'($urandom);
      value_i    = VALUE_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = op;
    column_i   = col;
    value_i    = val;
    do @(posedge clk_i); while (in_stall_o);
    fold_item(op, col, val, has_res, res);
    if (has_res) sums_due.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    int waited;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (sums_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sums_due.size() != 0) begin
      note_fail($sformatf("%0d results never arrived", sums_due.size()));
      sums_due.delete();
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [COLUMN_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    active_cols = v;
  endtask

  // mostly accumulate and read on a small set of columns; unset columns get a clip first
  task automatic random_burst(input int n, input int pool);
    int useful;
    int issued;
    int pick;
    logic [CMD_W-1:0] op;
    logic [COLUMN_W-1:0] col;
    logic [VALUE_W-1:0] val;
    useful = 0;
    issued = 0;
    while (useful < n && issued < 8 * n) begin
      if ($urandom_range(15) == 0) col = COLUMN_W'($urandom);
      else col = COLUMN_W'($urandom_range(pool - 1));
      pick = $urandom_range(99);
      if (pick < 10) op = CMD_SET_CLIP;
      else if (pick < 68) op = CMD_ACCUMULATE;
      else if (pick < 95) op = CMD_READ;
      else op = CMD_UNUSED;
      case ($urandom_range(7))
        0: val = 24'h800000;
        1: val = 24'h7FFFFF;
        2: val = $urandom_range(1) ? 24'h000000 : 24'hFFFFFF;
        default: val = VALUE_W'($urandom);
      endcase
      if (col < active_cols && col < MAX_COLUMNS && op != CMD_UNUSED) begin
        if (!col_set[col]) op = CMD_SET_CLIP;
        useful++;
      end
      offer(op, col, val, 1'b0, '0);
      issued++;
    end
  endtask

  // receiver side
  always begin
    @(negedge clk_i);
    if (hold_req && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = idle_on && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk_i) begin
    col_sums_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        note_fail($sformatf("unexpected result for column %0d", result_column_o));
      end else begin
        want = sums_due.pop_front();
        if (result_column_o !== want.col || clipped_sum_o !== want.sum ||
            clipped_sum_sq_o !== want.sq)
          note_fail($sformatf("col %0d/%0d sum %0d/%0d sq %0d/%0d (exp/got)",
                              want.col, result_column_o, want.sum, clipped_sum_o,
                              want.sq, clipped_sum_sq_o));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    column_i    = '0;
    value_i     = '0;
    out_stall_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++)
      offer(SCRIPT[i].op, SCRIPT[i].col, SCRIPT[i].val, SCRIPT[i].typed,
            col_sums_t'{SCRIPT[i].col, SCRIPT[i].sum, SCRIPT[i].sq});
    settle();

    write_active(16'd0);
    random_burst(4, 32);
    settle();

    write_active(16'd1);
    random_burst(30, 4);
    settle();

    write_active(16'd16);
    idle_on = 1'b0;
    random_burst(60, 24);
    idle_on = 1'b1;
    random_burst(120, 24);
    settle();

    // long receiver hold-off so the block backs up onto its input
    write_active(16'hFFFF);
    hold_req = 1'b1;
    random_burst(250, 40);
    settle();

    // extreme values on two columns, back to back
    write_active(ACTIVE_RESET);
    idle_on = 1'b0;
    offer(CMD_SET_CLIP, 16'd5, 24'h7FFFFF, 1'b0, '0);
    repeat (3) offer(CMD_ACCUMULATE, 16'd5, 24'h800000, 1'b0, '0);
    offer(CMD_READ, 16'd5, 24'h0, 1'b0, '0);
    repeat (3) offer(CMD_ACCUMULATE, 16'd5, 24'h800000, 1'b0, '0);
    offer(CMD_READ, 16'd5, 24'h0, 1'b0, '0);
    offer(CMD_ACCUMULATE, 16'd5, 24'h7FFFFF, 1'b0, '0);
    offer(CMD_READ, 16'd5, 24'h0, 1'b0, '0);
    offer(CMD_SET_CLIP, 16'd6, 24'h7FFFFF, 1'b0, '0);
    repeat (3) offer(CMD_ACCUMULATE, 16'd6, 24'h7FFFFF, 1'b0, '0);
    offer(CMD_READ, 16'd6, 24'h0, 1'b0, '0);
    offer(CMD_ACCUMULATE, 16'd6, 24'h800000, 1'b0, '0);
    offer(CMD_READ, 16'd6, 24'h0, 1'b0, '0);
    settle();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
design/scma_pkg.sv
design/scma_ram.sv
design/scma_sat.sv
design/sparse_clipped_moment_accumulator.sv
tb/sv/testbench.sv
